// ===== design/mcpwm_pkg.sv =====
// Shared widths, codes and reset values for the multi-channel PWM generator.
package mcpwm_pkg;

  localparam int DUTY_W      = 16;
  localparam int PIN_W       = 4;
  localparam int LEVELS_W    = 16;
  localparam int CNT_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int NUM_PINS_DEF = 16;

  localparam logic [CNT_W-1:0] CYCLE_COUNT_RST = 16'd4;
  localparam logic [CNT_W-1:0] STEP_TICKS_RST  = 16'd8;
  localparam logic [CNT_W-1:0] MAX_DUTY_RST    = 16'd255;
  localparam logic             COUNT_DOWN_RST  = 1'b0;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CYCLE_COUNT = 2'd0,
    CFG_STEP_TICKS  = 2'd1,
    CFG_MAX_DUTY    = 2'd2,
    CFG_COUNT_DOWN  = 2'd3
  } cfg_reg_t;

endpackage

// ===== design/multi_channel_pwm_generator.sv =====
// Multi-channel counter-compare PWM generator top level.
//
// Input channel (in_valid / in_stall): each transfer is either a duty write
// (in_op = write) that queues in_duty for pin in_pin, or one PWM clock tick.
// A queued write is applied at the start of the next group of cycle_count
// periods or empty-group tick; a second write to a still-queued pin is dropped.
// Result channel (out_valid / out_stall): exactly one result per input item,
// carrying the pin levels, the compare index and whether queued writes were
// applied by this item.
// The result is valid in the cycle after the input transfer. One item is
// accepted every cycle while in_stall is low; the whole per-item update
// (counter advance, duty compare across all pins) is a single pass into
// the state registers. The result register is the only buffer: an input is
// taken whenever the result register is empty or is being read, so a stalled
// receiver stalls the input side in the same cycle; nothing is lost or
// repeated. The configuration port (cfg_valid / cfg_ready) is always ready;
// the user must write registers only while idle (the block does not check).
// Synchronous reset clears all counters, levels, duty and pending flags and
// loads cycle_count = 4, step_ticks = 8, max_duty = 255, count_down = 0.
module multi_channel_pwm_generator #(
  parameter int NUM_PINS = mcpwm_pkg::NUM_PINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [mcpwm_pkg::PIN_W-1:0]         in_pin,
  input  logic [mcpwm_pkg::DUTY_W-1:0]        in_duty,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mcpwm_pkg::LEVELS_W-1:0]      out_pin_levels,
  output logic [mcpwm_pkg::CNT_W-1:0]         out_step_index,
  output logic                                out_updates_applied,
  // configuration port
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mcpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mcpwm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mcpwm_pkg::*;

  // configuration registers
  logic [CNT_W-1:0] cycle_count_r;
  logic [CNT_W-1:0] step_ticks_r;
  logic [CNT_W-1:0] max_duty_r;
  logic             count_down_r;

  // PWM state
  logic [DUTY_W-1:0]   duty_r       [NUM_PINS];
  logic [DUTY_W-1:0]   duty_nxt     [NUM_PINS];
  logic [DUTY_W-1:0]   pend_duty_r  [NUM_PINS];
  logic [DUTY_W-1:0]   pend_duty_nxt[NUM_PINS];
  logic [NUM_PINS-1:0] enabled_r, enabled_nxt;
  logic [NUM_PINS-1:0] pend_r, pend_nxt;
  logic [NUM_PINS-1:0] level_r, level_nxt;
  logic [CNT_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0]    period_r, period_nxt;
  logic [CNT_W-1:0]    prescale_r, prescale_nxt;

  // result register
  logic                out_valid_r;
  logic [LEVELS_W-1:0] out_levels_r, out_levels_nxt;
  logic [CNT_W-1:0]    out_index_r, out_index_nxt;
  logic                out_applied_r, out_applied_nxt;

  logic in_accept;
  logic cfg_write;

  // per-tick helpers
  logic             empty_group;
  logic [CNT_W-1:0] eff_ticks;
  logic [CNT_W-1:0] period_adj, cmp_idx_adj, prescale_adj;
  logic             group_start;
  logic [CNT_W-1:0] idx_tick, idx_hold;
  logic [CNT_W:0]   prescale_inc, cmp_idx_inc, period_inc;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  assign out_valid           = out_valid_r;
  assign out_pin_levels      = out_levels_r;
  assign out_step_index      = out_index_r;
  assign out_updates_applied = out_applied_r;

  assign empty_group = (cycle_count_r == '0) | (max_duty_r == '0);
  assign eff_ticks   = (step_ticks_r == '0) ? CNT_W'(1) : step_ticks_r;

  // A bound may have shrunk under a counter through a register write.
  assign period_adj   = (period_r   >= cycle_count_r) ? '0 : period_r;
  assign cmp_idx_adj  = (cmp_idx_r  >= max_duty_r)    ? '0 : cmp_idx_r;
  assign prescale_adj = (prescale_r >= eff_ticks)     ? '0 : prescale_r;
  assign group_start  = (period_adj == '0) & (cmp_idx_adj == '0) & (prescale_adj == '0);

  assign idx_tick = count_down_r ? (max_duty_r - CNT_W'(1) - cmp_idx_adj) : cmp_idx_adj;
  assign idx_hold = (empty_group | (cmp_idx_r >= max_duty_r)) ? '0 :
                    (count_down_r ? (max_duty_r - CNT_W'(1) - cmp_idx_r) : cmp_idx_r);

  assign prescale_inc = {1'b0, prescale_adj} + (CNT_W+1)'(1);
  assign cmp_idx_inc  = {1'b0, cmp_idx_adj}  + (CNT_W+1)'(1);
  assign period_inc   = {1'b0, period_adj}   + (CNT_W+1)'(1);

  always_comb begin
    duty_nxt        = duty_r;
    pend_duty_nxt   = pend_duty_r;
    enabled_nxt     = enabled_r;
    pend_nxt        = pend_r;
    level_nxt       = level_r;
    cmp_idx_nxt     = cmp_idx_r;
    period_nxt      = period_r;
    prescale_nxt    = prescale_r;
    out_index_nxt   = idx_hold;
    out_applied_nxt = 1'b0;

    if (in_op == OP_WRITE) begin
      // Queue the write unless this pin already has one waiting.
      for (int i = 0; i < NUM_PINS; i++) begin
        if (32'(in_pin) == i && !pend_r[i]) begin
          pend_duty_nxt[i] = in_duty;
          pend_nxt[i]      = 1'b1;
        end
      end
    end else begin
      if ((empty_group || group_start) && pend_r != '0) begin
        out_applied_nxt = 1'b1;
        pend_nxt        = '0;
        for (int i = 0; i < NUM_PINS; i++) begin
          if (pend_r[i]) begin
            duty_nxt[i] = pend_duty_r[i];
            if (pend_duty_r[i] == '0) begin
              enabled_nxt[i] = 1'b0;
              level_nxt[i]   = 1'b0;
            end else begin
              enabled_nxt[i] = 1'b1;
            end
          end
        end
      end

      if (empty_group) begin
        cmp_idx_nxt   = '0;
        period_nxt    = '0;
        prescale_nxt  = '0;
        out_index_nxt = '0;
      end else begin
        out_index_nxt = idx_tick;
        // Pins are compared only on the first tick of a step.
        if (prescale_adj == '0) begin
          for (int i = 0; i < NUM_PINS; i++) begin
            if (enabled_nxt[i]) begin
              level_nxt[i] = (duty_nxt[i] > idx_tick);
            end
          end
        end
        prescale_nxt = prescale_inc[CNT_W-1:0];
        cmp_idx_nxt  = cmp_idx_adj;
        period_nxt   = period_adj;
        if (prescale_inc >= {1'b0, eff_ticks}) begin
          prescale_nxt = '0;
          cmp_idx_nxt  = cmp_idx_inc[CNT_W-1:0];
          if (cmp_idx_inc >= {1'b0, max_duty_r}) begin
            cmp_idx_nxt = '0;
            period_nxt  = period_inc[CNT_W-1:0];
            if (period_inc >= {1'b0, cycle_count_r}) begin
              period_nxt = '0;
            end
          end
        end
      end
    end
  end

  // Pins beyond NUM_PINS read as low; pins beyond the port width are not shown.
  for (genvar b = 0; b < LEVELS_W; b++) begin : g_levels
    if (b < NUM_PINS) begin : g_pin
      assign out_levels_nxt[b] = level_nxt[b];
    end else begin : g_none
      assign out_levels_nxt[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_count_r <= CYCLE_COUNT_RST;
      step_ticks_r  <= STEP_TICKS_RST;
      max_duty_r    <= MAX_DUTY_RST;
      count_down_r  <= COUNT_DOWN_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CYCLE_COUNT: cycle_count_r <= cfg_data;
        CFG_STEP_TICKS:  step_ticks_r  <= cfg_data;
        CFG_MAX_DUTY:    max_duty_r    <= cfg_data;
        CFG_COUNT_DOWN:  count_down_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PINS; i++) begin
        duty_r[i] <= '0;
      end
      enabled_r  <= '0;
      pend_r     <= '0;
      level_r    <= '0;
      cmp_idx_r  <= '0;
      period_r   <= '0;
      prescale_r <= '0;
    end else if (in_accept) begin
      duty_r     <= duty_nxt;
      enabled_r  <= enabled_nxt;
      pend_r     <= pend_nxt;
      level_r    <= level_nxt;
      cmp_idx_r  <= cmp_idx_nxt;
      period_r   <= period_nxt;
      prescale_r <= prescale_nxt;
    end
  end

  // Queued duty values need no reset: an entry is read only while its pending bit is set.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_duty_r <= pend_duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_levels_r  <= out_levels_nxt;
      out_index_r   <= out_index_nxt;
      out_applied_r <= out_applied_nxt;
    end
  end

endmodule

// ===== verif/multi_channel_pwm_generator_test.sv =====
// Self-checking testbench for the multi-channel PWM generator with a built-in duty/compare predictor.
module multi_channel_pwm_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcpwm_pkg::*;

  localparam int NPINS = NUM_PINS_DEF;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1850;

  typedef struct packed {
    op_t                op;
    logic [PIN_W-1:0]   pin;
    logic [DUTY_W-1:0]  duty;
  } pwm_item_t;

  typedef struct packed {
    logic [LEVELS_W-1:0] pin_levels;
    logic [CNT_W-1:0]    step_index;
    logic                updates_applied;
  } pwm_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_op = 1'b0;
  logic [PIN_W-1:0]      in_pin = '0;
  logic [DUTY_W-1:0]     in_duty = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LEVELS_W-1:0]   out_pin_levels;
  logic [CNT_W-1:0]      out_step_index;
  logic                  out_updates_applied;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  multi_channel_pwm_generator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_pin              (in_pin),
    .in_duty             (in_duty),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pin_levels      (out_pin_levels),
    .out_step_index      (out_step_index),
    .out_updates_applied (out_updates_applied),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: registers and the PWM engine.
  logic [CNT_W-1:0]    reg_cycle_count;
  logic [CNT_W-1:0]    reg_step_ticks;
  logic [CNT_W-1:0]    reg_max_duty;
  logic                reg_count_down;
  logic [DUTY_W-1:0]   duty_tbl [NPINS];
  logic [DUTY_W-1:0]   queued_duty [NPINS];
  logic [NPINS-1:0]    enabled_mask;
  logic [NPINS-1:0]    queued_mask;
  logic [NPINS-1:0]    level_bits;
  logic [CNT_W-1:0]    cmp_pos;
  logic [CNT_W-1:0]    period_cnt;
  logic [CNT_W-1:0]    prescale_cnt;

  pwm_item_t   pending_items [$];
  pwm_result_t predicted_outputs [$];
  pwm_item_t   drive_item;
  pwm_result_t want_result;
  int          items_queued = 0;
  int          items_checked = 0;
  int          send_gap = 0;
  int          send_calm = 0;
  int          take_gap = 0;
  int          take_calm = 0;
  int          idle_cycles = 0;
  bit          failed = 1'b0;

  function automatic void reset_pwm_model();
    reg_cycle_count = CYCLE_COUNT_RST;
    reg_step_ticks  = STEP_TICKS_RST;
    reg_max_duty    = MAX_DUTY_RST;
    reg_count_down  = COUNT_DOWN_RST;
    for (int p = 0; p < NPINS; p++) begin
      duty_tbl[p] = '0;
      queued_duty[p] = '0;
    end
    enabled_mask = '0;
    queued_mask  = '0;
    level_bits   = '0;
    cmp_pos      = '0;
    period_cnt   = '0;
    prescale_cnt = '0;
  endfunction

  function automatic int shown_step(logic [CNT_W-1:0] pos);
    if (reg_max_duty == '0 || reg_cycle_count == '0 || pos >= reg_max_duty)
      return 0;
    return reg_count_down ? int'(reg_max_duty) - 1 - int'(pos) : int'(pos);
  endfunction

  function automatic logic apply_queued();
    if (queued_mask == '0)
      return 1'b0;
    for (int p = 0; p < NPINS; p++) begin
      if (queued_mask[p]) begin
        duty_tbl[p] = queued_duty[p];
        enabled_mask[p] = (queued_duty[p] != '0);
        if (queued_duty[p] == '0)
          level_bits[p] = 1'b0;
      end
    end
    queued_mask = '0;
    return 1'b1;
  endfunction

  // Advances the PWM engine by one item and returns the result it produces.
  function automatic pwm_result_t advance_pwm(pwm_item_t it);
    pwm_result_t r;
    int eff;
    int shown;
    r.updates_applied = 1'b0;
    if (it.op == OP_WRITE) begin
      if (!queued_mask[it.pin]) begin
        queued_duty[it.pin] = it.duty;
        queued_mask[it.pin] = 1'b1;
      end
      shown = shown_step(cmp_pos);
    end else if (reg_cycle_count == '0 || reg_max_duty == '0) begin
      cmp_pos = '0;
      period_cnt = '0;
      prescale_cnt = '0;
      r.updates_applied = apply_queued();
      shown = 0;
    end else begin
      eff = (reg_step_ticks == '0) ? 1 : int'(reg_step_ticks);
      // Counters left beyond a bound that was lowered restart first.
      if (period_cnt >= reg_cycle_count) period_cnt = '0;
      if (cmp_pos >= reg_max_duty) cmp_pos = '0;
      if (int'(prescale_cnt) >= eff) prescale_cnt = '0;
      if (period_cnt == '0 && cmp_pos == '0 && prescale_cnt == '0)
        r.updates_applied = apply_queued();
      shown = shown_step(cmp_pos);
      if (prescale_cnt == '0) begin
        for (int p = 0; p < NPINS; p++) begin
          if (enabled_mask[p])
            level_bits[p] = (int'(duty_tbl[p]) > shown);
        end
      end
      prescale_cnt = prescale_cnt + 1'b1;
      if (int'(prescale_cnt) >= eff) begin
        prescale_cnt = '0;
        cmp_pos = cmp_pos + 1'b1;
        if (cmp_pos >= reg_max_duty) begin
          cmp_pos = '0;
          period_cnt = period_cnt + 1'b1;
          if (period_cnt >= reg_cycle_count)
            period_cnt = '0;
        end
      end
    end
    r.pin_levels = level_bits;
    r.step_index = CNT_W'(shown);
    return r;
  endfunction

  // Draws the wait before the next transfer; calm stretches draw no wait at all.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0)
      calm = $urandom_range(20, 80);
    return $urandom_range(0, 5);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid)
        predicted_outputs.push_back(advance_pwm(drive_item));
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        drive_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_op    <= drive_item.op;
        in_pin   <= drive_item.pin;
        in_duty  <= drive_item.duty;
        send_gap = draw_wait(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_outputs.size() == 0) begin
          $error("result transfer with nothing expected: pin_levels %h step_index %h",
                 out_pin_levels, out_step_index);
          failed = 1'b1;
        end else begin
          want_result = predicted_outputs.pop_front();
          if (out_pin_levels !== want_result.pin_levels) begin
            $error("pin_levels: expected %h, actual %h", want_result.pin_levels, out_pin_levels);
            failed = 1'b1;
          end
          if (out_step_index !== want_result.step_index) begin
            $error("step_index: expected %0d, actual %0d",
                   want_result.step_index, out_step_index);
            failed = 1'b1;
          end
          if (out_updates_applied !== want_result.updates_applied) begin
            $error("updates_applied: expected %b, actual %b",
                   want_result.updates_applied, out_updates_applied);
            failed = 1'b1;
          end
          items_checked++;
        end
        take_gap = draw_wait(take_calm);
      end
      if (take_gap > 0) begin
        take_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send(op_t op, int pin, int duty);
    pwm_item_t it;
    it.op   = op;
    it.pin  = PIN_W'(pin);
    it.duty = DUTY_W'(duty);
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Holds off until every queued item has produced its checked result.
  task automatic drain();
    while (items_checked != items_queued)
      @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CYCLE_COUNT: reg_cycle_count = CNT_W'(value);
      CFG_STEP_TICKS:  reg_step_ticks  = CNT_W'(value);
      CFG_MAX_DUTY:    reg_max_duty    = CNT_W'(value);
      CFG_COUNT_DOWN:  reg_count_down  = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(int cycles, int ticks, int steps, int down);
    drain();
    write_reg(CFG_CYCLE_COUNT, cycles);
    write_reg(CFG_STEP_TICKS, ticks);
    write_reg(CFG_MAX_DUTY, steps);
    write_reg(CFG_COUNT_DOWN, down);
  endtask

  initial begin
    int random_sent;
    int n;
    int duty;
    random_sent = 0;
    reset_pwm_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: nothing pending at the first group start, then a batch of
    // writes including a repeat to a pending pin and a disabling write.
    send(OP_TICK, 0, 0);
    send(OP_WRITE, 0, 16'hFFFF);
    send(OP_WRITE, 15, 1);
    send(OP_WRITE, 7, 16'h0080);
    send(OP_WRITE, 0, 16'h1234);
    send(OP_WRITE, 3, 0);
    repeat (4) send(OP_TICK, 0, 0);

    // One-period groups of two steps counting down; the prescaler is left
    // above the new step length.
    configure(1, 0, 2, 1);
    send(OP_WRITE, 15, 0);
    send(OP_WRITE, 8, 16'hAAAA);
    send(OP_TICK, 0, 0);
    send(OP_TICK, 0, 0);
    send(OP_WRITE, 7, 16'h5555);
    repeat (4) send(OP_TICK, 0, 0);

    // Empty groups: zero cycle count, then zero steps.
    drain();
    write_reg(CFG_CYCLE_COUNT, 0);
    send(OP_WRITE, 1, 2);
    send(OP_TICK, 0, 0);
    send(OP_TICK, 0, 0);
    drain();
    write_reg(CFG_CYCLE_COUNT, 3);
    write_reg(CFG_MAX_DUTY, 0);
    send(OP_WRITE, 2, 7);
    send(OP_TICK, 0, 0);

    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent == 0)
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
      else if ($urandom_range(0, 5) == 0)
        configure($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                  $urandom_range(0, 16'hFFFF), $urandom_range(0, 1));
      else
        configure($urandom_range(0, 3), $urandom_range(0, 3),
                  $urandom_range(0, 8), $urandom_range(0, 1));
      n = $urandom_range(60, 160);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0:       duty = 0;
          1:       duty = 16'hFFFF;
          2:       duty = $urandom_range(0, 16'hFFFF);
          default: duty = $urandom_range(0, int'(reg_max_duty) + 1);
        endcase
        if ($urandom_range(0, 9) < 7)
          send(OP_TICK, $urandom_range(0, NPINS - 1), $urandom_range(0, 16'hFFFF));
        else
          send(OP_WRITE, $urandom_range(0, NPINS - 1), duty);
        random_sent++;
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (!failed)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
